[rtl/core/spr_pkg.sv]
// Shared types, codes and a helper function for the strike pulse controller.
package spr_pkg;

  localparam int STAMP_DEPTH = 16;
  localparam int TIME_W  = 32;
  localparam int WIN_W   = 24;
  localparam int PLEN_W  = 16;
  localparam int LIMIT_W = 4;
  localparam int WCNT_W  = $clog2(STAMP_DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int RIDX_W  = 3;

  // Operation codes carried by an input beat.
  localparam logic [1:0] FN_TICK = 2'd0;
  localparam logic [1:0] FN_REQ  = 2'd1;
  localparam logic [1:0] FN_ON   = 2'd2;
  localparam logic [1:0] FN_OFF  = 2'd3;

  // Reason codes.
  localparam logic [1:0] RS_OK       = 2'd0;
  localparam logic [1:0] RS_DISABLED = 2'd1;
  localparam logic [1:0] RS_LOCKED   = 2'd2;
  localparam logic [1:0] RS_LOCK_NEW = 2'd3;

  // Pin modes.
  localparam logic [1:0] PM_FLOAT    = 2'd0;
  localparam logic [1:0] PM_PULLUP   = 2'd1;
  localparam logic [1:0] PM_PULLDOWN = 2'd2;
  localparam logic [1:0] PM_OUTPUT   = 2'd3;

  // Idle modes.
  localparam logic [2:0] IM_PULLUP   = 3'd0;
  localparam logic [2:0] IM_PULLDOWN = 3'd1;
  localparam logic [2:0] IM_FLOAT    = 3'd2;
  localparam logic [2:0] IM_HIGH     = 3'd3;
  localparam logic [2:0] IM_LOW      = 3'd4;

  // Register indexes.
  localparam logic [RIDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [RIDX_W-1:0] REG_ACTIVE_HIGH = 3'd1;
  localparam logic [RIDX_W-1:0] REG_IDLE_MODE   = 3'd2;
  localparam logic [RIDX_W-1:0] REG_PULSE_LEN   = 3'd3;
  localparam logic [RIDX_W-1:0] REG_MAX_PULSE   = 3'd4;
  localparam logic [RIDX_W-1:0] REG_ACT_LIMIT   = 3'd5;
  localparam logic [RIDX_W-1:0] REG_LOCKOUT_LEN = 3'd6;
  localparam logic [RIDX_W-1:0] REG_WINDOW_LEN  = 3'd7;

  typedef struct packed {
    logic [1:0]        func;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic [1:0]        reason_code;
    logic [1:0]        pin_mode;
    logic              pin_level;
    logic              pulse_active;
    logic              logical_on;
    logic              lock_active;
    logic [TIME_W-1:0] pulse_remaining_ms;
    logic [TIME_W-1:0] lockout_remaining_ms;
    logic [WCNT_W-1:0] window_count;
  } out_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       level;
  } pin_t;

  // Control for the row of stamp cells.
  typedef struct packed {
    logic clear;
    logic prune;
    logic push;
  } cell_ctl_t;

  // Returns the pin after moving to the idle mode; a disabled block leaves it alone.
  function automatic pin_t go_idle(input logic en, input logic [2:0] idle, input pin_t cur);
    pin_t p;
    p = cur;
    if (en) begin
      unique case (idle)
        IM_PULLUP:   p.mode = PM_PULLUP;
        IM_PULLDOWN: p.mode = PM_PULLDOWN;
        IM_FLOAT:    p.mode = PM_FLOAT;
        IM_HIGH: begin
          p.mode  = PM_OUTPUT;
          p.level = 1'b1;
        end
        default: begin
          p.mode  = PM_OUTPUT;
          p.level = 1'b0;
        end
      endcase
    end
    return p;
  endfunction

endpackage

[rtl/core/spr_cell.sv]
// One activation stamp cell of the window chain.
module spr_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  spr_pkg::cell_ctl_t         ctl,
  input  logic [spr_pkg::TIME_W-1:0] now,
  input  logic [spr_pkg::WIN_W-1:0]  window,
  input  logic [spr_pkg::TIME_W-1:0] prev_stamp,
  input  logic                       prev_valid,
  input  logic                       hole_in,
  output logic [spr_pkg::TIME_W-1:0] stamp,
  output logic                       valid,
  output logic                       hole_out
);
  import spr_pkg::*;

  logic [TIME_W-1:0] stamp_r;
  logic              valid_r;
  logic [TIME_W-1:0] age;
  logic              keep;
  logic              take;

  assign age  = now - stamp_r;
  assign keep = age <= TIME_W'(window);
  // A push moves every cell up to and including the first empty one.
  assign take = ctl.push && !hole_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= prev_valid;
    end else if (ctl.prune) begin
      valid_r <= valid_r && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stamp_r <= prev_stamp;
    end
  end

  assign stamp    = stamp_r;
  assign valid    = valid_r;
  assign hole_out = hole_in || !valid_r;

endmodule

[rtl/core/strike_pulse_with_rate_lockout.sv]
// Top level of the strike pulse controller with sliding-window rate lockout.
//
// A command beat (tick, pulse request, manual on, manual off, with the current
// millisecond time) is taken when start is high and busy is low, and exactly
// one result beat follows on out_item, marked by out_valid for a single cycle;
// the receiver cannot stall it, so it must sample every strobe. Each command
// then passes a prune state, in which every stamp cell compares its age against
// the window in parallel, a count state that counts surviving stamps from the
// cell valid flags, and a finish state that decides, pushes the new stamp into
// the cell row and registers the result. busy drops while the result is
// presented, so a new command may be given in the same cycle that out_valid
// is high. The stamp cells hold only valid flags under reset; no clearing pass
// is needed. Registers are to be written through the APB-style port only while
// no command is in flight; the block does not enforce it. Any write clears the
// stamps, flags and deadlines and moves the pin to idle mode (float if disabled).
module strike_pulse_with_rate_lockout (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  spr_pkg::in_item_t          in_item,
  output logic                       out_valid,
  output spr_pkg::out_item_t         out_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spr_pkg::ADDR_W-1:0] paddr,
  input  logic [spr_pkg::DATA_W-1:0] pwdata,
  output logic [spr_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import spr_pkg::*;

  localparam int CNT_W = $clog2(STAMP_DEPTH + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PRUNE  = 4'b0010,
    ST_COUNT  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic               enable_r;
  logic               active_high_r;
  logic [2:0]         idle_mode_r;
  logic [PLEN_W-1:0]  pulse_len_r;
  logic [PLEN_W-1:0]  max_pulse_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [WIN_W-1:0]   lockout_len_r;
  logic [WIN_W-1:0]   window_len_r;

  // Controller state.
  logic              active_r, active_nxt;
  logic              logical_r, logical_nxt;
  logic [TIME_W-1:0] pulse_dl_r, pulse_dl_nxt;
  logic [TIME_W-1:0] lock_dl_r, lock_dl_nxt;
  pin_t              pin_r, pin_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // The command being worked on.
  logic [1:0]        func_r;
  logic [TIME_W-1:0] now_r;

  logic              out_valid_r;
  out_item_t         out_item_r, out_item_nxt;

  logic              cfg_wr;
  logic [RIDX_W-1:0] cfg_idx;
  logic              en_new;
  logic [2:0]        idle_new;

  logic              lock_pre;
  logic              prune_req;
  logic              do_push;
  cell_ctl_t         ctl;

  logic [TIME_W-1:0] stamp_q [STAMP_DEPTH];
  logic              valid_q [STAMP_DEPTH];
  logic              hole_q  [STAMP_DEPTH+1];

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;
  assign busy    = (state_r != ST_IDLE);

  // Register values as they stand after this cycle's write, for the idle move.
  assign en_new   = (cfg_wr && cfg_idx == REG_ENABLE) ? pwdata[0] : enable_r;
  assign idle_new = (cfg_wr && cfg_idx == REG_IDLE_MODE) ? pwdata[2:0] : idle_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      active_high_r <= 1'b1;
      idle_mode_r   <= IM_FLOAT;
      pulse_len_r   <= PLEN_W'(500);
      max_pulse_r   <= PLEN_W'(5000);
      limit_r       <= '0;
      lockout_len_r <= WIN_W'(60000);
      window_len_r  <= WIN_W'(10000);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ENABLE:      enable_r      <= pwdata[0];
        REG_ACTIVE_HIGH: active_high_r <= pwdata[0];
        REG_IDLE_MODE:   idle_mode_r   <= pwdata[2:0];
        REG_PULSE_LEN:   pulse_len_r   <= pwdata[PLEN_W-1:0];
        REG_MAX_PULSE:   max_pulse_r   <= pwdata[PLEN_W-1:0];
        REG_ACT_LIMIT:   limit_r       <= pwdata[LIMIT_W-1:0];
        REG_LOCKOUT_LEN: lockout_len_r <= pwdata[WIN_W-1:0];
        REG_WINDOW_LEN:  window_len_r  <= pwdata[WIN_W-1:0];
        default:         enable_r      <= enable_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ENABLE:      prdata = DATA_W'(enable_r);
      REG_ACTIVE_HIGH: prdata = DATA_W'(active_high_r);
      REG_IDLE_MODE:   prdata = DATA_W'(idle_mode_r);
      REG_PULSE_LEN:   prdata = DATA_W'(pulse_len_r);
      REG_MAX_PULSE:   prdata = DATA_W'(max_pulse_r);
      REG_ACT_LIMIT:   prdata = DATA_W'(limit_r);
      REG_LOCKOUT_LEN: prdata = DATA_W'(lockout_len_r);
      REG_WINDOW_LEN:  prdata = DATA_W'(window_len_r);
      default:         prdata = '0;
    endcase
  end

  // Sequencer: accept, prune, count, finish.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_PRUNE;
      ST_PRUNE:  state_nxt = ST_COUNT;
      ST_COUNT:  state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      func_r <= in_item.func;
      now_r  <= in_item.now_ms;
    end
  end

  // Lockout is a plain unsigned compare against the wrapping deadline.
  assign lock_pre = lock_dl_r > now_r;

  // Ticks always prune; pulse requests and manual on prune only past the gates.
  assign prune_req = (func_r == FN_TICK) ||
                     (enable_r && (func_r == FN_REQ || func_r == FN_ON) && !lock_pre);

  assign ctl.clear = cfg_wr;
  assign ctl.prune = (state_r == ST_PRUNE) && prune_req;
  assign ctl.push  = (state_r == ST_FINISH) && do_push;

  // The cell row: cell 0 holds the newest stamp and the last cell the oldest.
  assign hole_q[0] = 1'b0;

  for (genvar i = 0; i < STAMP_DEPTH; i++) begin : g_cell
    logic [TIME_W-1:0] prev_stamp;
    logic              prev_valid;
    if (i == 0) begin : g_head
      assign prev_stamp = now_r;
      assign prev_valid = 1'b1;
    end else begin : g_link
      assign prev_stamp = stamp_q[i-1];
      assign prev_valid = valid_q[i-1];
    end
    spr_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .now        (now_r),
      .window     (window_len_r),
      .prev_stamp (prev_stamp),
      .prev_valid (prev_valid),
      .hole_in    (hole_q[i]),
      .stamp      (stamp_q[i]),
      .valid      (valid_q[i]),
      .hole_out   (hole_q[i+1])
    );
  end

  // Number of stamps held, taken from the cell flags after the prune cycle.
  always_comb begin
    cnt_nxt = '0;
    for (int i = 0; i < STAMP_DEPTH; i++) begin
      cnt_nxt = cnt_nxt + CNT_W'(valid_q[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (state_r == ST_COUNT) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Decision for the command in the finish cycle, and the clear on a write.
  always_comb begin
    logic [CNT_W-1:0]  new_cnt;
    logic [CNT_W-1:0]  cnt_fin;
    logic [PLEN_W-1:0] plen;
    logic              over;
    logic              accepted;
    logic [1:0]        reason;
    logic              level;
    logic              locked_post;

    active_nxt   = active_r;
    logical_nxt  = logical_r;
    pulse_dl_nxt = pulse_dl_r;
    lock_dl_nxt  = lock_dl_r;
    pin_nxt      = pin_r;
    do_push      = 1'b0;
    accepted     = 1'b1;
    reason       = RS_OK;
    cnt_fin      = cnt_r;

    // A full row drops its oldest stamp, so the count saturates at the depth.
    new_cnt = (cnt_r == CNT_W'(STAMP_DEPTH)) ? cnt_r : cnt_r + CNT_W'(1);
    over    = (limit_r != '0) && (CMP_W'(new_cnt) > CMP_W'(limit_r));
    plen    = (pulse_len_r < max_pulse_r) ? pulse_len_r : max_pulse_r;

    // Manual on uses the active level as is; a pulse request against a
    // driven idle level uses the opposite of that level.
    level = active_high_r;
    if (func_r == FN_REQ && idle_mode_r == IM_HIGH) begin
      level = 1'b0;
    end else if (func_r == FN_REQ && idle_mode_r == IM_LOW) begin
      level = 1'b1;
    end

    if (cfg_wr) begin
      active_nxt   = 1'b0;
      logical_nxt  = 1'b0;
      pulse_dl_nxt = '0;
      lock_dl_nxt  = '0;
      if (en_new) begin
        pin_nxt = go_idle(en_new, idle_new, pin_r);
      end else begin
        pin_nxt.mode = PM_FLOAT;
      end
    end else if (state_r == ST_FINISH) begin
      priority if (func_r == FN_TICK) begin
        if (active_r && now_r > pulse_dl_r) begin
          active_nxt  = 1'b0;
          logical_nxt = 1'b0;
          pin_nxt     = go_idle(enable_r, idle_mode_r, pin_r);
        end
      end else if (!enable_r) begin
        accepted = 1'b0;
        reason   = RS_DISABLED;
      end else if (func_r == FN_OFF) begin
        active_nxt  = 1'b0;
        logical_nxt = 1'b0;
        pin_nxt     = go_idle(enable_r, idle_mode_r, pin_r);
      end else if (lock_pre) begin
        accepted = 1'b0;
        reason   = RS_LOCKED;
      end else begin
        do_push = 1'b1;
        cnt_fin = new_cnt;
        if (over) begin
          // The pulse flags and deadline stay as they were.
          lock_dl_nxt = now_r + TIME_W'(lockout_len_r);
          pin_nxt     = go_idle(enable_r, idle_mode_r, pin_r);
          accepted    = 1'b0;
          reason      = RS_LOCK_NEW;
        end else begin
          pin_nxt.mode  = PM_OUTPUT;
          pin_nxt.level = level;
          active_nxt    = 1'b1;
          logical_nxt   = 1'b1;
          pulse_dl_nxt  = now_r + TIME_W'(plen);
        end
      end
    end

    locked_post = lock_dl_nxt > now_r;

    out_item_nxt.accepted             = accepted;
    out_item_nxt.reason_code          = reason;
    out_item_nxt.pin_mode             = pin_nxt.mode;
    out_item_nxt.pin_level            = pin_nxt.level;
    out_item_nxt.pulse_active         = active_nxt;
    out_item_nxt.logical_on           = logical_nxt;
    out_item_nxt.lock_active          = locked_post;
    out_item_nxt.pulse_remaining_ms   = active_nxt ? pulse_dl_nxt - now_r : '0;
    out_item_nxt.lockout_remaining_ms = locked_post ? lock_dl_nxt - now_r : '0;
    out_item_nxt.window_count         = WCNT_W'(cnt_fin);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      logical_r   <= 1'b0;
      pulse_dl_r  <= '0;
      lock_dl_r   <= '0;
      pin_r       <= '{mode: PM_FLOAT, level: 1'b0};
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      logical_r   <= logical_nxt;
      pulse_dl_r  <= pulse_dl_nxt;
      lock_dl_r   <= lock_dl_nxt;
      pin_r       <= pin_nxt;
      out_valid_r <= (state_r == ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A result beat is shown only once the sequencer is back to idle.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_IDLE))
    else $error("result beat while a command is still in flight");

  // An accepted command starts the prune cycle next.
  a_start_to_prune: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_PRUNE))
    else $error("accepted command did not enter the prune cycle");

  // The stamp count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STAMP_DEPTH))
    else $error("stamp count above depth");

  // A refused command is never reported as accepted.
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.reason_code != RS_OK) |-> !out_item.accepted)
    else $error("refused command reported as accepted");

  // The cell row is only pushed in the finish cycle.
  a_push_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> (state_r == ST_FINISH) && !ctl.prune)
    else $error("stamp push outside the finish cycle");

endmodule
